FILE: hw/rtl/btpo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btpo_pkg;

  localparam int unsigned ID_W  = 4;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned BOX_W = 4 * COORD_W;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CMD_W = 2;

  // Command codes (s_axis_tuser[1:0])
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd3;

  // Kind codes
  localparam logic KIND_STATIC  = 1'b0;
  localparam logic KIND_MOVABLE = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] STAT_OK   = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL = 2'd1;
  localparam logic [ST_W-1:0] STAT_BAD  = 2'd2;

  // Outcome of a table command, slot table to top level
  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] new_id;
    logic            wr_en;
    logic [ID_W-1:0] wr_id;
  } slot_res_t;

  // Packed box: [15:0] left_x, [31:16] top_y, [47:32] right_x, [63:48] bottom_y
  function automatic logic boxes_overlap(input logic [BOX_W-1:0] a,
                                         input logic [BOX_W-1:0] b);
    logic signed [COORD_W-1:0] al, at, ar, ab, bl, bt, br, bb;
    al = a[15:0];  at = a[31:16]; ar = a[47:32]; ab = a[63:48];
    bl = b[15:0];  bt = b[31:16]; br = b[47:32]; bb = b[63:48];
    // touching edges still count
    return !((ab < bt) || (at > bb) || (ar < bl) || (al > br));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/btpo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module btpo_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/btpo_slots.sv
`timescale 1ns / 1ps
`default_nettype none

module btpo_slots #(
  parameter int unsigned STATIC_SLOTS  = 8,
  parameter int unsigned MOVABLE_SLOTS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         apply_i,
  input  wire logic [btpo_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic                         kind_i,
  input  wire logic [btpo_pkg::ID_W-1:0]    box_id_i,
  output btpo_pkg::slot_res_t               res_o,
  output logic      [STATIC_SLOTS-1:0]      static_used_o,
  output logic      [MOVABLE_SLOTS-1:0]     movable_used_o
);

  localparam int unsigned IW = btpo_pkg::ID_W;
  localparam logic [IW-1:0] S_ID   = IW'(STATIC_SLOTS);
  localparam logic [IW-1:0] ALL_ID = IW'(STATIC_SLOTS + MOVABLE_SLOTS);

  logic [STATIC_SLOTS-1:0]  static_used_q, static_used_d;
  logic [MOVABLE_SLOTS-1:0] movable_used_q, movable_used_d;

  logic            st_found, mv_found;
  logic [IW-1:0]   st_idx, mv_idx;
  logic [IW-1:0]   mv_off;
  logic            st_bit, mv_bit, id_is_st, id_is_mv;

  // lowest free slot of each kind
  always_comb begin
    st_found = 1'b0;
    st_idx   = '0;
    for (int i = STATIC_SLOTS - 1; i >= 0; i--) begin
      if (!static_used_q[i]) begin
        st_found = 1'b1;
        st_idx   = IW'(i);
      end
    end
    mv_found = 1'b0;
    mv_idx   = '0;
    for (int i = MOVABLE_SLOTS - 1; i >= 0; i--) begin
      if (!movable_used_q[i]) begin
        mv_found = 1'b1;
        mv_idx   = IW'(i);
      end
    end
  end

  assign id_is_st = box_id_i < S_ID;
  assign id_is_mv = !id_is_st && (box_id_i < ALL_ID);
  assign mv_off   = box_id_i - S_ID;
  assign st_bit   = id_is_st && |(static_used_q & (STATIC_SLOTS'(1) << box_id_i));
  assign mv_bit   = id_is_mv && |(movable_used_q & (MOVABLE_SLOTS'(1) << mv_off));

  always_comb begin
    res_o          = '0;
    static_used_d  = static_used_q;
    movable_used_d = movable_used_q;
    case (cmd_i)
      btpo_pkg::CMD_ADD: begin
        if (kind_i == btpo_pkg::KIND_MOVABLE) begin
          if (mv_found) begin
            res_o.status   = btpo_pkg::STAT_OK;
            res_o.new_id   = S_ID + mv_idx;
            res_o.wr_en    = 1'b1;
            res_o.wr_id    = S_ID + mv_idx;
            movable_used_d = movable_used_q | (MOVABLE_SLOTS'(1) << mv_idx);
          end else begin
            res_o.status = btpo_pkg::STAT_FULL;
          end
        end else begin
          if (st_found) begin
            res_o.status  = btpo_pkg::STAT_OK;
            res_o.new_id  = st_idx;
            res_o.wr_en   = 1'b1;
            res_o.wr_id   = st_idx;
            static_used_d = static_used_q | (STATIC_SLOTS'(1) << st_idx);
          end else begin
            res_o.status = btpo_pkg::STAT_FULL;
          end
        end
      end
      btpo_pkg::CMD_REMOVE: begin
        res_o.status = btpo_pkg::STAT_BAD;
        if (kind_i == btpo_pkg::KIND_MOVABLE) begin
          if (mv_bit) begin
            res_o.status   = btpo_pkg::STAT_OK;
            movable_used_d = movable_used_q & ~(MOVABLE_SLOTS'(1) << mv_off);
          end
        end else if (st_bit) begin
          res_o.status  = btpo_pkg::STAT_OK;
          static_used_d = static_used_q & ~(STATIC_SLOTS'(1) << box_id_i);
        end
      end
      btpo_pkg::CMD_UPDATE: begin
        res_o.status = (st_bit || mv_bit) ? btpo_pkg::STAT_OK : btpo_pkg::STAT_BAD;
        res_o.wr_en  = st_bit || mv_bit;
        res_o.wr_id  = box_id_i;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      static_used_q  <= '0;
      movable_used_q <= '0;
    end else if (apply_i) begin
      static_used_q  <= static_used_d;
      movable_used_q <= movable_used_d;
    end
  end

  assign static_used_o  = static_used_q;
  assign movable_used_o = movable_used_q;

endmodule

`default_nettype wire

FILE: hw/rtl/box_table_pairwise_overlap.sv
`timescale 1ns / 1ps
`default_nettype none

// Box table with all-pairs overlap sweep. Keeps STATIC_SLOTS static and
// MOVABLE_SLOTS movable axis-aligned boxes in one synchronous box RAM, with
// occupancy masks in flops. Input words carry add, remove, update or sweep
// commands; every table command answers with exactly one output word
// (status, new id). A sweep walks each occupied movable box in rising
// slot order and reads it into a holding register, then steps through every
// id in rising order, reading each candidate (occupied static slot, or later
// occupied movable slot) from the RAM and comparing it with the held box.
// One output word per overlapping pair, tlast on the final pair; a sweep
// with no pair gives a single all-zero word with tlast. Touching edges count.
// A sweep also waits out output back-pressure. The walk reads one box at a
// time through the single read port of the box RAM. Boxes of free slots are
// never read, so the RAM needs no clearing after reset. A new word is taken
// while the previous result still waits, provided the output register is
// drained in that cycle.
module box_table_pairwise_overlap #(
  parameter int unsigned STATIC_SLOTS  = 8,
  parameter int unsigned MOVABLE_SLOTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [3:0] box_id, [19:4] left_x, [35:20] top_y, [51:36] right_x,
  // [67:52] bottom_y, [71:68] zero
  input  wire logic [71:0] s_axis_tdata_i,
  // [1:0] cmd, [2] kind
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [5:2] new_id, [9:6] first_id, [13:10] second_id, [15:14] zero
  output logic [15:0]      m_axis_tdata_o,
  // [0] hit
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned IW  = btpo_pkg::ID_W;
  localparam int unsigned BW  = btpo_pkg::BOX_W;
  localparam int unsigned ALL = STATIC_SLOTS + MOVABLE_SLOTS;
  localparam int unsigned AW  = $clog2(ALL);
  localparam int unsigned JW  = $clog2(ALL + 1);
  localparam int unsigned MW  = $clog2(MOVABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT_M,
    S_LOAD_A,
    S_SCAN,
    S_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // input word fields
  logic [btpo_pkg::CMD_W-1:0] in_cmd;
  logic                       in_kind;
  logic [IW-1:0]              in_id;
  logic [BW-1:0]              in_box;

  assign in_cmd  = s_axis_tuser_i[1:0];
  assign in_kind = s_axis_tuser_i[2];
  assign in_id   = s_axis_tdata_i[3:0];
  assign in_box  = s_axis_tdata_i[67:4];

  logic out_free, in_acc;
  btpo_pkg::slot_res_t slot_res;
  logic [STATIC_SLOTS-1:0]  static_used;
  logic [MOVABLE_SLOTS-1:0] movable_used;

  // output register
  logic          out_vld_q, out_vld_d;
  logic [15:0]   out_data_q, out_data_d;
  logic          out_hit_q, out_hit_d;
  logic          out_last_q, out_last_d;

  // sweep walk
  logic [MW-1:0] m_q, m_d;
  logic [JW-1:0] j_q, j_d;
  logic [BW-1:0] a_q, a_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_first_q, pend_first_d;
  logic [IW-1:0] pend_second_q, pend_second_d;

  // RAM read side
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_data;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  btpo_slots #(
    .STATIC_SLOTS  (STATIC_SLOTS),
    .MOVABLE_SLOTS (MOVABLE_SLOTS)
  ) u_slots (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .apply_i        (in_acc && (in_cmd != btpo_pkg::CMD_SWEEP)),
    .cmd_i          (in_cmd),
    .kind_i         (in_kind),
    .box_id_i       (in_id),
    .res_o          (slot_res),
    .static_used_o  (static_used),
    .movable_used_o (movable_used)
  );

  btpo_ram #(
    .WIDTH (BW),
    .DEPTH (ALL)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_cmd != btpo_pkg::CMD_SWEEP) && slot_res.wr_en),
    .waddr_i (slot_res.wr_id[AW-1:0]),
    .wdata_i (in_box),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // candidate test for id j against the held movable box m
  logic          j_is_st, st_bit, mv_bit, m_bit, j_later, cand, hit;
  logic [JW-1:0] j_mv;
  logic [IW-1:0] first_id, j_id;

  assign j_is_st  = j_q < JW'(STATIC_SLOTS);
  assign j_mv     = j_q - JW'(STATIC_SLOTS);
  assign st_bit   = |(static_used & (STATIC_SLOTS'(1) << j_q));
  assign mv_bit   = |(movable_used & (MOVABLE_SLOTS'(1) << j_mv));
  assign m_bit    = |(movable_used & (MOVABLE_SLOTS'(1) << m_q));
  assign j_later  = j_q > (JW'(STATIC_SLOTS) + JW'(m_q));
  assign cand     = j_is_st ? st_bit : (j_later && mv_bit);
  assign first_id = IW'(STATIC_SLOTS) + IW'(m_q);
  assign j_id     = IW'(j_q);
  assign hit      = btpo_pkg::boxes_overlap(a_q, rd_data);

  always_comb begin
    state_d       = state_q;
    out_vld_d     = out_vld_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    out_hit_d     = out_hit_q;
    out_last_d    = out_last_q;
    m_d           = m_q;
    j_d           = j_q;
    a_d           = a_q;
    pend_d        = pend_q;
    pend_first_d  = pend_first_q;
    pend_second_d = pend_second_q;
    rd_en         = 1'b0;
    rd_addr       = AW'(j_q);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == btpo_pkg::CMD_SWEEP) begin
            m_d     = '0;
            pend_d  = 1'b0;
            state_d = S_NEXT_M;
          end else begin
            out_vld_d  = 1'b1;
            out_data_d = {2'b00, {IW{1'b0}}, {IW{1'b0}}, slot_res.new_id, slot_res.status};
            out_hit_d  = 1'b0;
            out_last_d = 1'b1;
          end
        end
      end
      S_NEXT_M: begin
        if (m_q == MW'(MOVABLE_SLOTS)) begin
          state_d = S_FIN;
        end else if (m_bit) begin
          rd_en   = 1'b1;
          rd_addr = AW'(STATIC_SLOTS) + AW'(m_q);
          state_d = S_LOAD_A;
        end else begin
          m_d = m_q + MW'(1);
        end
      end
      S_LOAD_A: begin
        a_d     = rd_data;
        j_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q == JW'(ALL)) begin
          m_d     = m_q + MW'(1);
          state_d = S_NEXT_M;
        end else if (cand) begin
          rd_en   = 1'b1;
          state_d = S_CMP;
        end else begin
          j_d = j_q + JW'(1);
        end
      end
      S_CMP: begin
        // a found pair goes to the pending slot; the older one is sent on
        if (!(hit && pend_q && !out_free)) begin
          if (hit) begin
            if (pend_q) begin
              out_vld_d  = 1'b1;
              out_data_d = {2'b00, pend_second_q, pend_first_q, {IW{1'b0}},
                            btpo_pkg::STAT_OK};
              out_hit_d  = 1'b1;
              out_last_d = 1'b0;
            end
            pend_d        = 1'b1;
            pend_first_d  = first_id;
            pend_second_d = j_id;
          end
          j_d     = j_q + JW'(1);
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          out_hit_d  = pend_q;
          out_data_d = pend_q ? {2'b00, pend_second_q, pend_first_q, {IW{1'b0}},
                                 btpo_pkg::STAT_OK}
                              : '0;
          pend_d     = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_vld_q     <= 1'b0;
      out_data_q    <= '0;
      out_hit_q     <= 1'b0;
      out_last_q    <= 1'b0;
      m_q           <= '0;
      j_q           <= '0;
      a_q           <= '0;
      pend_q        <= 1'b0;
      pend_first_q  <= '0;
      pend_second_q <= '0;
    end else begin
      state_q       <= state_d;
      out_vld_q     <= out_vld_d;
      out_data_q    <= out_data_d;
      out_hit_q     <= out_hit_d;
      out_last_q    <= out_last_d;
      m_q           <= m_d;
      j_q           <= j_d;
      a_q           <= a_d;
      pend_q        <= pend_d;
      pend_first_q  <= pend_first_d;
      pend_second_q <= pend_second_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/btpo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module btpo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [2:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // a table command answers in the very next cycle
  a_table_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o &&
     (s_axis_tuser_i[1:0] != btpo_pkg::CMD_SWEEP)) |=> m_axis_tvalid_o)
    else $error("table command gave no reply word");

  // a new word is only taken when the pending result leaves in the same cycle
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && m_axis_tvalid_o) |-> m_axis_tready_i)
    else $error("input taken while result register blocked");

  // words without a pair always close their command
  a_nohit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("non-pair word without tlast");

  // pair words carry status ok and no new id
  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[5:0] == 6'd0))
    else $error("pair word with status or new id set");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output word changed");

endmodule

bind box_table_pairwise_overlap btpo_checker u_btpo_checker (.*);

`default_nettype wire

FILE: tb/box_table_pairwise_overlap_test.sv
`timescale 1ns / 1ps

module box_table_pairwise_overlap_test;

  localparam int unsigned STATIC_SLOTS  = 8;
  localparam int unsigned MOVABLE_SLOTS = 4;
  localparam int unsigned ALL_SLOTS     = STATIC_SLOTS + MOVABLE_SLOTS;
  localparam int RANDOM_WORDS = 205;
  localparam int TAIL_CYCLES  = 200;
  localparam int HOLD_CYCLES  = 300;
  // Slowest run: ~230 words, sweeps of up to 38 results each waiting out
  // receiver stalls, plus the long hold; taken several times over.
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [btpo_pkg::ST_W-1:0] status;
    logic [btpo_pkg::ID_W-1:0] new_id;
    logic                      hit;
    logic [btpo_pkg::ID_W-1:0] first_id;
    logic [btpo_pkg::ID_W-1:0] second_id;
    logic                      last;
  } result_word_t;

  // Tracks the slot tables and box store, predicts the output words of each
  // accepted command and checks the words that come out against them.
  class box_table_scoreboard;
    logic [STATIC_SLOTS-1:0]        static_used;
    logic [MOVABLE_SLOTS-1:0]       movable_used;
    logic [btpo_pkg::BOX_W-1:0]     boxes [ALL_SLOTS];
    result_word_t                   awaited_words [$];
    int                             errors;

    function new();
      static_used  = '0;
      movable_used = '0;
      errors       = 0;
      foreach (boxes[i]) boxes[i] = '0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Edges that touch still count as overlap.
    function bit boxes_meet(logic [btpo_pkg::BOX_W-1:0] a, logic [btpo_pkg::BOX_W-1:0] b);
      logic signed [btpo_pkg::COORD_W-1:0] al, at, ar, ab, bl, bt, br, bb;
      al = a[15:0]; at = a[31:16]; ar = a[47:32]; ab = a[63:48];
      bl = b[15:0]; bt = b[31:16]; br = b[47:32]; bb = b[63:48];
      if (ab < bt) return 1'b0;
      if (at > bb) return 1'b0;
      if (ar < bl) return 1'b0;
      if (al > br) return 1'b0;
      return 1'b1;
    endfunction

    function void push_word(logic [btpo_pkg::ST_W-1:0] st, logic [btpo_pkg::ID_W-1:0] nid,
                            logic hit, logic [btpo_pkg::ID_W-1:0] f,
                            logic [btpo_pkg::ID_W-1:0] s, logic last);
      result_word_t w;
      w.status = st; w.new_id = nid; w.hit = hit;
      w.first_id = f; w.second_id = s; w.last = last;
      awaited_words.push_back(w);
    endfunction

    function void note_command(logic [btpo_pkg::CMD_W-1:0] cmd, logic kind,
                               logic [btpo_pkg::ID_W-1:0] id,
                               logic [btpo_pkg::BOX_W-1:0] box);
      int                        pairs;
      bit                        done;
      bit                        occupied;
      logic [btpo_pkg::ST_W-1:0] st;
      result_word_t              w;
      pairs = 0;
      done  = 1'b0;
      case (cmd)
        btpo_pkg::CMD_ADD: begin
          if (kind == btpo_pkg::KIND_MOVABLE) begin
            for (int i = 0; i < MOVABLE_SLOTS; i++) begin
              if (!done && !movable_used[i]) begin
                movable_used[i] = 1'b1;
                boxes[STATIC_SLOTS + i] = box;
                push_word(btpo_pkg::STAT_OK, btpo_pkg::ID_W'(STATIC_SLOTS + i), 1'b0,
                          '0, '0, 1'b1);
                done = 1'b1;
              end
            end
          end else begin
            for (int i = 0; i < STATIC_SLOTS; i++) begin
              if (!done && !static_used[i]) begin
                static_used[i] = 1'b1;
                boxes[i] = box;
                push_word(btpo_pkg::STAT_OK, btpo_pkg::ID_W'(i), 1'b0, '0, '0, 1'b1);
                done = 1'b1;
              end
            end
          end
          if (!done) push_word(btpo_pkg::STAT_FULL, '0, 1'b0, '0, '0, 1'b1);
        end
        btpo_pkg::CMD_REMOVE: begin
          st = btpo_pkg::STAT_BAD;
          if (kind == btpo_pkg::KIND_STATIC) begin
            if (id < STATIC_SLOTS && static_used[id]) begin
              static_used[id] = 1'b0;
              st = btpo_pkg::STAT_OK;
            end
          end else if (id >= STATIC_SLOTS && id < ALL_SLOTS) begin
            if (movable_used[id - STATIC_SLOTS]) begin
              movable_used[id - STATIC_SLOTS] = 1'b0;
              st = btpo_pkg::STAT_OK;
            end
          end
          push_word(st, '0, 1'b0, '0, '0, 1'b1);
        end
        btpo_pkg::CMD_UPDATE: begin
          occupied = 1'b0;
          if (id < STATIC_SLOTS) occupied = static_used[id];
          else if (id < ALL_SLOTS) occupied = movable_used[id - STATIC_SLOTS];
          if (occupied) boxes[id] = box;
          push_word(occupied ? btpo_pkg::STAT_OK : btpo_pkg::STAT_BAD, '0, 1'b0, '0, '0,
                    1'b1);
        end
        default: begin
          // sweep: each movable box against statics, then later movables
          for (int m = 0; m < MOVABLE_SLOTS; m++) begin
            if (movable_used[m]) begin
              for (int s = 0; s < STATIC_SLOTS; s++) begin
                if (static_used[s] && boxes_meet(boxes[STATIC_SLOTS + m], boxes[s])) begin
                  push_word(btpo_pkg::STAT_OK, '0, 1'b1, btpo_pkg::ID_W'(STATIC_SLOTS + m),
                            btpo_pkg::ID_W'(s), 1'b0);
                  pairs++;
                end
              end
              for (int m2 = m + 1; m2 < MOVABLE_SLOTS; m2++) begin
                if (movable_used[m2] &&
                    boxes_meet(boxes[STATIC_SLOTS + m], boxes[STATIC_SLOTS + m2])) begin
                  push_word(btpo_pkg::STAT_OK, '0, 1'b1, btpo_pkg::ID_W'(STATIC_SLOTS + m),
                            btpo_pkg::ID_W'(STATIC_SLOTS + m2), 1'b0);
                  pairs++;
                end
              end
            end
          end
          if (pairs == 0) begin
            push_word(btpo_pkg::STAT_OK, '0, 1'b0, '0, '0, 1'b1);
          end else begin
            w = awaited_words.pop_back();
            w.last = 1'b1;
            awaited_words.push_back(w);
          end
        end
      endcase
    endfunction

    task check_field(string name, logic [3:0] got, logic [3:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_word(result_word_t got);
      result_word_t want;
      if (awaited_words.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want = awaited_words.pop_front();
      check_field("status", 4'(got.status), 4'(want.status));
      check_field("new_id", got.new_id, want.new_id);
      check_field("hit", 4'(got.hit), 4'(want.hit));
      check_field("first_id", got.first_id, want.first_id);
      check_field("second_id", got.second_id, want.second_id);
      check_field("last", 4'(got.last), 4'(want.last));
    endtask
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [71:0] in_data   = '0;
  logic [2:0]  in_user   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_data;
  logic        out_user;
  logic        out_last;

  box_table_scoreboard sb = new();
  bit calm      = 1'b0;   // no random idling on either side while set
  int words_out = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycles    = 0;

  box_table_pairwise_overlap #(
    .STATIC_SLOTS (STATIC_SLOTS),
    .MOVABLE_SLOTS(MOVABLE_SLOTS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tuser_o (out_user),
    .m_axis_tlast_o (out_last)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("box_table_pairwise_overlap regression: fail");
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off once traffic is flowing.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_out >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Output monitor, sampled at the edge before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      words_out++;
      sb.check_word({out_data[1:0], out_data[5:2], out_user, out_data[9:6],
                     out_data[13:10], out_last});
    end
  end

  // Offer one word, with random gaps in front, and wait for it to be taken.
  task automatic send_word(logic [btpo_pkg::CMD_W-1:0] cmd, logic kind,
                           logic [btpo_pkg::ID_W-1:0] id,
                           logic [btpo_pkg::BOX_W-1:0] box);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {4'b0, box, id};
    in_user  <= {kind, cmd};
    do @(posedge clk_i); while (!in_ready);
    sb.note_command(cmd, kind, id, box);
  endtask

  function automatic logic [btpo_pkg::BOX_W-1:0] pack_box(int l, int t, int r, int b);
    return {16'(b), 16'(r), 16'(t), 16'(l)};
  endfunction

  // Mostly small boxes near the origin, so pairs both meet and miss;
  // some inverted, some with fully random coordinates.
  function automatic logic [btpo_pkg::BOX_W-1:0] random_box();
    int roll, l, t, r, b;
    roll = $urandom_range(0, 7);
    l = int'($urandom_range(0, 80)) - 40;
    t = int'($urandom_range(0, 80)) - 40;
    r = l + int'($urandom_range(0, 30));
    b = t + int'($urandom_range(0, 30));
    if (roll == 0) return {$urandom(), $urandom()};
    if (roll == 1) return pack_box(r, b, l, t);
    return pack_box(l, t, r, b);
  endfunction

  logic [btpo_pkg::BOX_W-1:0] whole_plane;

  initial begin
    int roll;
    logic k;
    whole_plane = pack_box(-32768, -32768, 32767, 32767);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tables, bad ids, fill both tables, full tables.
    send_word(btpo_pkg::CMD_SWEEP, btpo_pkg::KIND_STATIC, 4'd0, '0);
    send_word(btpo_pkg::CMD_REMOVE, btpo_pkg::KIND_STATIC, 4'd0, '0);
    send_word(btpo_pkg::CMD_REMOVE, btpo_pkg::KIND_MOVABLE, 4'd3, '0);  // not a movable id
    send_word(btpo_pkg::CMD_REMOVE, btpo_pkg::KIND_STATIC, 4'd9, '0);   // not a static id
    send_word(btpo_pkg::CMD_UPDATE, btpo_pkg::KIND_STATIC, 4'd15, '1);  // beyond every slot
    send_word(btpo_pkg::CMD_UPDATE, btpo_pkg::KIND_MOVABLE, 4'd2, '1);  // free slot
    for (int i = 0; i < STATIC_SLOTS + 1; i++)
      send_word(btpo_pkg::CMD_ADD, btpo_pkg::KIND_STATIC, 4'd15, whole_plane);
    for (int i = 0; i < MOVABLE_SLOTS + 1; i++)
      send_word(btpo_pkg::CMD_ADD, btpo_pkg::KIND_MOVABLE, 4'd0, whole_plane);
    send_word(btpo_pkg::CMD_SWEEP, btpo_pkg::KIND_MOVABLE, 4'd15, '1);  // every pair meets
    // corner contact, and a box with its corners swapped
    send_word(btpo_pkg::CMD_UPDATE, btpo_pkg::KIND_STATIC, 4'd0, pack_box(0, 0, 10, 10));
    send_word(btpo_pkg::CMD_UPDATE, btpo_pkg::KIND_STATIC, 4'd8, pack_box(10, 10, 20, 20));
    send_word(btpo_pkg::CMD_UPDATE, btpo_pkg::KIND_STATIC, 4'd9,
              pack_box(32767, 32767, -32768, -32768));
    send_word(btpo_pkg::CMD_SWEEP, btpo_pkg::KIND_STATIC, 4'd0, '0);
    send_word(btpo_pkg::CMD_REMOVE, btpo_pkg::KIND_STATIC, 4'd3, '0);
    send_word(btpo_pkg::CMD_REMOVE, btpo_pkg::KIND_MOVABLE, 4'd9, '0);
    send_word(btpo_pkg::CMD_SWEEP, btpo_pkg::KIND_STATIC, 4'd0, '0);

    // Random: mostly updates, with table churn and regular sweeps.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 60 && n < 110);
      roll = $urandom_range(0, 99);
      k = 1'($urandom());
      if (roll < 12) begin
        send_word(btpo_pkg::CMD_SWEEP, k, 4'($urandom()), {$urandom(), $urandom()});
      end else if (roll < 30) begin
        send_word(btpo_pkg::CMD_ADD, k, 4'($urandom()), random_box());
      end else if (roll < 45) begin
        if ($urandom_range(0, 4) == 0)
          send_word(btpo_pkg::CMD_REMOVE, k, 4'($urandom()), {$urandom(), $urandom()});
        else if (k == btpo_pkg::KIND_MOVABLE)
          send_word(btpo_pkg::CMD_REMOVE, k,
                    4'($urandom_range(STATIC_SLOTS, ALL_SLOTS - 1)), '0);
        else
          send_word(btpo_pkg::CMD_REMOVE, k, 4'($urandom_range(0, STATIC_SLOTS - 1)), '0);
      end else if (roll < 92) begin
        send_word(btpo_pkg::CMD_UPDATE, k, 4'($urandom_range(0, ALL_SLOTS - 1)),
                  random_box());
      end else begin
        send_word(btpo_pkg::CMD_UPDATE, k, 4'($urandom()), random_box());
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.awaited_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("box_table_pairwise_overlap regression: pass");
    end else begin
      $display("box_table_pairwise_overlap regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/btpo_pkg.sv
hw/rtl/btpo_ram.sv
hw/rtl/btpo_slots.sv
hw/rtl/box_table_pairwise_overlap.sv
hw/rtl/btpo_checker.sv
tb/box_table_pairwise_overlap_test.sv
